// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the sieve unit RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define SPS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define SPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types, codes and widths of the segmented prime sieve unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

    localparam int SEGMENT_SIZE_DEF = 65536;

    localparam int DATA_W    = 64;
    localparam int OP_W      = 2;
    localparam int LEN_W     = 17;
    localparam int WI_W      = 10;
    localparam int ST_W      = 2;
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 128;

    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_SIEVE = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef enum logic [ST_W-1:0] {
        STS_OK         = 2'd0,
        STS_PRIME_ZERO = 2'd1,
        STS_BAD_INDEX  = 2'd2,
        STS_NO_SEGMENT = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_CLEAR,
        S_DIV,
        S_FIRST,
        S_RMW_RD,
        S_RMW_WR,
        S_WORD_RD,
        S_WORD_DATA,
        S_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

`default_nettype wire

// File: hdl/sps_ram.sv
// ----------------------------------------------------------------------------
// sps_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                             i_wdata,
    input  wire logic                                         i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hdl/sps_mod.sv
// ----------------------------------------------------------------------------
// sps_mod
// Radix-2 restoring remainder unit: one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_mod
    import sps_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DATA_W-1:0] i_dividend,
    input  wire logic [DATA_W-1:0] i_divisor,
    output t_div_sts               o_sts,
    output logic      [DATA_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(DATA_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [DATA_W-1:0] r_rem, n_rem;
    logic [DATA_W-1:0] r_dvd, n_dvd;
    logic [DATA_W-1:0] r_dvs, n_dvs;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;

    assign shifted = {r_rem, r_dvd[DATA_W-1]};
    assign diff    = shifted - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_dvd  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            // keep the shifted value when the trial subtract borrows
            n_rem = diff[DATA_W] ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
            n_dvd = {r_dvd[DATA_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DATA_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_rem      = r_rem;

endmodule

`default_nettype wire

// File: hdl/segmented_prime_sieve_unit.sv
// ----------------------------------------------------------------------------
// segmented_prime_sieve_unit
// Segmented sieve of Eratosthenes over one stored segment of survivor flags.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on the s_axis side carry op in tuser and number, length and
//   word_index in tdata. Each beat yields one result beat on m_axis: flags and
//   word_base in tdata, status in tuser.
//   Start segment: the survivor map is written one 64-entry word per cycle.
//   Sieve: the remainder unit finds the first multiple in the segment; each
//   multiple is then cleared by a read (S_RMW_RD) and a write (S_RMW_WR) of
//   its map word, so a prime of one over a full segment takes longest.
//   Read word: the map word is read (S_WORD_RD), then masked (S_WORD_DATA).
//   One item is worked at a time; tready is high only while the sequencer is
//   idle. A finished result sits in an output register, so the next item is
//   taken and worked while the receiver stalls; its result then waits until
//   the register frees.
//   Reset clears the control state and marks no segment started. The map
//   itself is not cleared; reads and sieves before a start return status 3.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module segmented_prime_sieve_unit
    import sps_pkg::*;
#(
    parameter int SEGMENT_SIZE = SEGMENT_SIZE_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // [63:0] number, [80:64] length, [90:81] word_index, [95:91] zero
    input  wire logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // [1:0] op
    input  wire logic [OP_W-1:0]      i_s_axis_tuser,
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    // [63:0] flags, [127:64] word_base
    output logic      [M_TDATA_W-1:0] o_m_axis_tdata,
    // [1:0] status
    output logic      [ST_W-1:0]      o_m_axis_tuser
);

    localparam int MAP_WORDS = (SEGMENT_SIZE + 63) / 64;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int IDX_W     = AW + 6;
    localparam int CNT_W     = IDX_W + 1;

    function automatic logic [DATA_W-1:0] live_mask(input logic [AW:0] w,
                                                    input logic [CNT_W-1:0] cnt);
        logic [AW:0]       full_words;
        logic [DATA_W-1:0] m;
        full_words = cnt[CNT_W-1:6];
        if (w < full_words) begin
            m = '1;
        end else if (w == full_words) begin
            m = ~({DATA_W{1'b1}} << cnt[5:0]);
        end else begin
            m = '0;
        end
        return m;
    endfunction

    t_state            r_state, n_state;
    t_op               r_op, n_op;
    logic [DATA_W-1:0] r_num, n_num;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [WI_W-1:0]   r_wi, n_wi;

    logic [DATA_W-1:0] r_low, n_low;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_ready, n_ready;
    logic [AW-1:0]     r_addr, n_addr;
    logic [IDX_W-1:0]  r_idx, n_idx;

    logic [DATA_W-1:0] r_res_flags, n_res_flags;
    logic [DATA_W-1:0] r_res_base, n_res_base;
    t_status           r_res_status, n_res_status;

    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_flags, n_out_flags;
    logic [DATA_W-1:0] r_out_base, n_out_base;
    t_status           r_out_status, n_out_status;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;

    logic              div_start;
    t_div_sts          div_sts;
    logic [DATA_W-1:0] div_rem;

    logic              in_beat;
    logic              out_free;
    logic [DATA_W-1:0] len_sat;
    logic [DATA_W-1:0] neg_low;
    logic [CNT_W-1:0]  seg_count;
    logic              read_bad;
    logic [DATA_W-1:0] first_idx;
    logic              first_in;
    logic [CNT_W-1:0]  left;
    logic              last_hit;

    sps_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    sps_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_low),
        .i_divisor  (r_num),
        .o_sts      (div_sts),
        .o_rem      (div_rem)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_beat         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    // saturate the length, then cut it so the last entry stays below 2^64
    assign len_sat   = (DATA_W'(r_len) > DATA_W'(SEGMENT_SIZE)) ?
                       DATA_W'(SEGMENT_SIZE) : DATA_W'(r_len);
    assign neg_low   = '0 - r_num;
    assign seg_count = ((r_num != '0) && (len_sat > neg_low)) ?
                       CNT_W'(neg_low) : CNT_W'(len_sat);

    assign read_bad  = (DATA_W'({r_wi, 6'd0}) >= DATA_W'(r_count)) ||
                       (DATA_W'(r_wi) >= DATA_W'(MAP_WORDS));

    assign first_idx = (div_rem == '0) ? '0 : r_num - div_rem;
    assign first_in  = first_idx < DATA_W'(r_count);
    assign left      = r_count - {1'b0, r_idx};
    assign last_hit  = r_num >= DATA_W'(left);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (r_op)
                    OP_START: n_state = S_CLEAR;
                    OP_SIEVE: n_state = (!r_ready || r_num == '0) ? S_DONE : S_DIV;
                    OP_READ:  n_state = (!r_ready || read_bad) ? S_DONE : S_WORD_RD;
                    default:  n_state = S_DONE;
                endcase
            end
            S_CLEAR: begin
                if (r_addr == AW'(MAP_WORDS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                if (div_sts.done) begin
                    n_state = S_FIRST;
                end
            end
            S_FIRST:     n_state = first_in ? S_RMW_RD : S_DONE;
            S_RMW_RD:    n_state = S_RMW_WR;
            S_RMW_WR:    n_state = last_hit ? S_DONE : S_RMW_RD;
            S_WORD_RD:   n_state = S_WORD_DATA;
            S_WORD_DATA: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_op         = r_op;
        n_num        = r_num;
        n_len        = r_len;
        n_wi         = r_wi;
        n_low        = r_low;
        n_count      = r_count;
        n_ready      = r_ready;
        n_addr       = r_addr;
        n_idx        = r_idx;
        n_res_flags  = r_res_flags;
        n_res_base   = r_res_base;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_flags  = r_out_flags;
        n_out_base   = r_out_base;
        n_out_status = r_out_status;
        ram_we       = 1'b0;
        ram_waddr    = r_addr;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = r_idx[IDX_W-1:6];
        div_start    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_op  = t_op'(i_s_axis_tuser);
                    n_num = i_s_axis_tdata[63:0];
                    n_len = i_s_axis_tdata[80:64];
                    n_wi  = i_s_axis_tdata[90:81];
                end
            end
            S_DISPATCH: begin
                n_res_flags  = '0;
                n_res_base   = '0;
                n_res_status = STS_OK;
                case (r_op)
                    OP_START: begin
                        n_low   = r_num;
                        n_count = seg_count;
                        n_ready = 1'b1;
                        n_addr  = '0;
                    end
                    OP_SIEVE: begin
                        if (!r_ready) begin
                            n_res_status = STS_NO_SEGMENT;
                        end else if (r_num == '0) begin
                            n_res_status = STS_PRIME_ZERO;
                        end else begin
                            div_start = 1'b1;
                        end
                    end
                    OP_READ: begin
                        if (!r_ready) begin
                            n_res_status = STS_NO_SEGMENT;
                        end else if (read_bad) begin
                            n_res_status = STS_BAD_INDEX;
                        end
                    end
                    default: begin
                        n_res_status = STS_OK;
                    end
                endcase
            end
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                ram_wdata = live_mask({1'b0, r_addr}, r_count);
                n_addr    = r_addr + 1'b1;
            end
            S_FIRST: begin
                n_idx = IDX_W'(first_idx);
            end
            S_RMW_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_idx[IDX_W-1:6];
            end
            S_RMW_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx[IDX_W-1:6];
                ram_wdata = ram_rdata & ~({{(DATA_W-1){1'b0}}, 1'b1} << r_idx[5:0]);
                // advance only while the next multiple stays inside the segment
                if (!last_hit) begin
                    n_idx = r_idx + r_num[IDX_W-1:0];
                end
            end
            S_WORD_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = AW'(r_wi);
                n_res_base = r_low + DATA_W'({r_wi, 6'd0});
            end
            S_WORD_DATA: begin
                n_res_flags = ram_rdata & live_mask((AW + 1)'(r_wi), r_count);
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_flags  = r_res_flags;
                    n_out_base   = r_res_base;
                    n_out_status = r_res_status;
                end
            end
            default: begin
                n_out_valid = r_out_valid && !i_m_axis_tready;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ready     <= 1'b0;
            r_low       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ready     <= n_ready;
            r_low       <= n_low;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_op         <= n_op;
        r_num        <= n_num;
        r_len        <= n_len;
        r_wi         <= n_wi;
        r_addr       <= n_addr;
        r_idx        <= n_idx;
        r_res_flags  <= n_res_flags;
        r_res_base   <= n_res_base;
        r_res_status <= n_res_status;
        r_out_flags  <= n_out_flags;
        r_out_base   <= n_out_base;
        r_out_status <= n_out_status;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_base, r_out_flags};
    assign o_m_axis_tuser  = r_out_status;

    `SPS_ASSERT_IMPL(a_idle_div_quiet, i_clk, i_rst_n, o_s_axis_tready, !div_sts.busy,
        "remainder unit busy while the sequencer is idle")
    `SPS_ASSERT_IMPL(a_rmw_in_segment, i_clk, i_rst_n, r_state == S_RMW_WR,
        {1'b0, r_idx} < r_count, "clearing an entry outside the segment")
    `SPS_ASSERT_IMPL(a_map_write_src, i_clk, i_rst_n, ram_we,
        (r_state == S_CLEAR) || (r_state == S_RMW_WR), "map written outside sweep or sieve")
    `SPS_ASSERT_IMPL(a_err_no_data, i_clk, i_rst_n,
        o_m_axis_tvalid && (o_m_axis_tuser != STS_OK), o_m_axis_tdata == '0,
        "error result carries data")
    `SPS_ASSERT_NEXT(a_done_posts, i_clk, i_rst_n, (r_state == S_DONE) && out_free,
        o_m_axis_tvalid, "finished item not posted to the output register")

endmodule

`default_nettype wire

// File: tb/sv/segmented_prime_sieve_unit_test.sv
// ----------------------------------------------------------------------------
// segmented_prime_sieve_unit_test
// Drives start, sieve, read and unused-op beats into the sieve unit. A
// scoreboard keeps its own survivor map and compares every result beat, in
// order, with the word, base and status it predicts.
// ----------------------------------------------------------------------------
`default_nettype none

module segmented_prime_sieve_unit_test;
    import sps_pkg::*;

    localparam int          MAP_WORDS    = SEGMENT_SIZE_DEF / 64;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam int          RANDOM_ITEMS = 75;
    localparam int          HOLD_CYCLES  = 2000;
    localparam int          DRAIN_CYCLES = 50;
    // Must exceed the longest item: prime one sieved over a full segment.
    localparam int          STALL_LIMIT  = 500000;

    typedef struct {
        logic [DATA_W-1:0] flags;
        logic [DATA_W-1:0] base;
        logic [ST_W-1:0]   status;
    } t_sieve_reply;

    class sieve_scoreboard;
        logic [DATA_W-1:0] seg_low;
        logic [LEN_W-1:0]  seg_count;
        bit                seg_ready;
        logic [63:0]       flag_map [MAP_WORDS];
        t_sieve_reply      awaited [$];
        int                mismatches;
        int                compared;
        int                op_count [4];

        function new();
            seg_low    = '0;
            seg_count  = '0;
            seg_ready  = 1'b0;
            mismatches = 0;
            compared   = 0;
            foreach (op_count[i]) op_count[i] = 0;
            foreach (flag_map[w]) flag_map[w] = '0;
        endfunction

        // Entries of word w that lie inside the segment.
        function logic [63:0] word_mask(int unsigned w);
            logic [63:0] first;
            logic [63:0] left;
            first = 64'(w) * 64;
            if (first >= 64'(seg_count)) return '0;
            left = 64'(seg_count) - first;
            if (left >= 64) return '1;
            return (64'd1 << left) - 64'd1;
        endfunction

        function void strike_multiples(logic [63:0] p);
            logic [63:0] rem;
            logic [63:0] idx;
            logic [63:0] cnt;
            cnt = 64'(seg_count);
            rem = seg_low % p;
            idx = (rem == 0) ? 64'd0 : p - rem;
            while (idx < cnt) begin
                flag_map[int'((idx >> 6) % MAP_WORDS)][idx[5:0]] = 1'b0;
                // stop before idx + p could wrap past the top
                if (p >= cnt - idx) break;
                idx += p;
            end
        endfunction

        function void note_item(logic [1:0] op, logic [63:0] number, logic [LEN_W-1:0] length,
                                logic [WI_W-1:0] wi);
            t_sieve_reply r;
            logic [63:0]  len;
            r.flags  = '0;
            r.base   = '0;
            r.status = STS_OK;
            op_count[op]++;
            case (op)
                OP_START: begin
                    len = 64'(length);
                    if (len > 64'(SEGMENT_SIZE_DEF)) len = 64'(SEGMENT_SIZE_DEF);
                    // cut the segment so its last entry stays below 2^64
                    if (number != 0 && len > (64'd0 - number)) len = 64'd0 - number;
                    seg_low   = number;
                    seg_count = len[LEN_W-1:0];
                    seg_ready = 1'b1;
                    for (int w = 0; w < MAP_WORDS; w++) flag_map[w] = word_mask(w);
                end
                OP_SIEVE: begin
                    if (!seg_ready) r.status = STS_NO_SEGMENT;
                    else if (number == 0) r.status = STS_PRIME_ZERO;
                    else strike_multiples(number);
                end
                OP_READ: begin
                    if (!seg_ready) begin
                        r.status = STS_NO_SEGMENT;
                    end else if (64'(wi) * 64 >= 64'(seg_count)) begin
                        r.status = STS_BAD_INDEX;
                    end else begin
                        r.flags = flag_map[wi] & word_mask(wi);
                        r.base  = seg_low + 64'(wi) * 64;
                    end
                end
                default: ;
            endcase
            awaited.insert(awaited.size(), r);
        endfunction

        function void check_reply(logic [63:0] flags, logic [63:0] base, logic [ST_W-1:0] status);
            t_sieve_reply want;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: flags %h base %h status %0d",
                             flags, base, status);
                return;
            end
            want = awaited.pop_front();
            compared++;
            if (flags !== want.flags || base !== want.base || status !== want.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("beat %0d mismatch: flags exp %h got %h, base exp %h got %h, %s",
                             compared, want.flags, flags, want.base, base,
                             $sformatf("status exp %0d got %0d", want.status, status));
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [OP_W-1:0]      s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [ST_W-1:0]      m_tuser;

    sieve_scoreboard sb;
    int burst_left    = 0;
    int worked_items  = 0;
    int hold_requests = 0;
    int holds_served  = 0;

    segmented_prime_sieve_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Offer one beat and hold it until accepted; mostly idle between bursts.
    task automatic send_item(input logic [1:0] op, input logic [63:0] number,
                             input logic [LEN_W-1:0] length, input logic [WI_W-1:0] wi);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'd0, wi, length, number};
        do @(posedge clk); while (s_tready !== 1'b1);
        sb.note_item(op, number, length, wi);
        burst_left--;
        if (op != OP_UNUSED) worked_items++;
    endtask

    // Start a segment, sieve it a few times, read back some of its words.
    task automatic random_sequence();
        logic [63:0]      low;
        logic [63:0]      p;
        logic [LEN_W-1:0] len;
        logic [WI_W-1:0]  wi;
        int               words;
        case ($urandom_range(0, 3))
            0:       low = 64'($urandom_range(0, 5000));
            1:       low = 64'd0 - 64'($urandom_range(1, 400));
            default: low = rand64();
        endcase
        case ($urandom_range(0, 11))
            0:       len = '0;
            1:       len = LEN_W'($urandom_range(65536, 131071));
            2:       len = LEN_W'($urandom);
            default: len = LEN_W'($urandom_range(1, 300));
        endcase
        send_item(OP_START, low, len, WI_W'($urandom));
        repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 9))
                0:       p = '0;
                1:       p = rand64();
                2:       p = 64'($urandom_range(1000, 1000000));
                // keep small primes off large segments to bound run time
                default: p = (sb.seg_count > 2048) ? 64'($urandom_range(11, 3000))
                                                   : 64'($urandom_range(1, 40));
            endcase
            send_item(OP_SIEVE, p, LEN_W'($urandom), WI_W'($urandom));
        end
        words = (int'(sb.seg_count) + 63) / 64;
        repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(0, 7))
                0:       wi = WI_W'($urandom);
                1:       wi = (words > 0) ? WI_W'(words - 1) : WI_W'($urandom);
                default: wi = (words > 0) ? WI_W'($urandom_range(0, words - 1)) : '0;
            endcase
            send_item(OP_READ, rand64(), LEN_W'($urandom), wi);
        end
    endtask

    initial begin : stimulus
        int base_items;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // before any segment: no-segment status, unused op
        send_item(OP_READ, '0, '0, '0);
        send_item(OP_SIEVE, 64'd5, '0, '0);
        send_item(OP_UNUSED, rand64(), LEN_W'($urandom), WI_W'($urandom));
        // small segment from zero: prime zero, two primes, partial and bad words
        send_item(OP_START, 64'd0, LEN_W'(100), '0);
        send_item(OP_SIEVE, 64'd0, '0, '0);
        send_item(OP_SIEVE, 64'd2, '0, '0);
        send_item(OP_SIEVE, 64'd3, '0, '0);
        send_item(OP_READ, '0, '0, WI_W'(0));
        send_item(OP_READ, '0, '0, WI_W'(1));
        send_item(OP_READ, '0, '0, WI_W'(2));
        send_item(OP_READ, '0, '0, '1);
        // segment at the top of the number range, cut short; largest 64-bit value as prime
        send_item(OP_START, 64'd0 - 64'd40, LEN_W'(200), '0);
        send_item(OP_SIEVE, '1, '0, '0);
        send_item(OP_READ, '0, '0, '0);
        // empty segment
        send_item(OP_START, 64'd1000, '0, '0);
        send_item(OP_SIEVE, 64'd7, '0, '0);
        send_item(OP_READ, '0, '0, '0);
        // prime one clears everything
        send_item(OP_START, 64'd30, LEN_W'(64), '0);
        send_item(OP_SIEVE, 64'd1, '0, '0);
        send_item(OP_READ, '0, '0, '0);
        // length saturates to a full segment
        send_item(OP_START, rand64(), '1, '0);
        send_item(OP_SIEVE, 64'd65537, '0, '0);
        send_item(OP_READ, '0, '0, '1);
        send_item(OP_READ, '0, '0, '0);
        send_item(OP_UNUSED, '1, '1, '1);

        base_items = worked_items;
        while (worked_items < base_items + RANDOM_ITEMS) begin
            if (hold_requests == 0 && worked_items >= base_items + 40) hold_requests = 1;
            if ($urandom_range(0, 9) < 8)
                random_sequence();
            else
                send_item(2'($urandom_range(1, 3)), rand64(), LEN_W'($urandom), WI_W'($urandom));
        end
        s_tvalid <= 1'b0;

        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d segment starts, %0d sieve passes, %0d word reads, %0d unused beats",
                 sb.op_count[OP_START], sb.op_count[OP_SIEVE], sb.op_count[OP_READ],
                 sb.op_count[OP_UNUSED]);
        $display("%0d result beats compared, %0d mismatches, one output hold of %0d cycles",
                 sb.compared, sb.mismatches, HOLD_CYCLES);
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin : receiver
        int hold_left;
        int mode_left;
        int mode;
        int rx_cycle;
        hold_left = 0;
        mode_left = 0;
        mode      = 0;
        rx_cycle  = 0;
        forever begin
            @(posedge clk);
            rx_cycle++;
            if (rst_n && m_tvalid === 1'b1 && m_tready)
                sb.check_reply(m_tdata[63:0], m_tdata[127:64], m_tuser);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                // hold off so the unit fills up and stalls its input
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 160);
                end
                mode_left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= (rx_cycle % 3) != 0;
                    default: m_tready <= (rx_cycle % 7) == 0;
                endcase
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
